FILE: sv/fnv1a64_pkg.sv
// fnv1a64_pkg: constants, operation codes, command/status types and the fold function
// shared by the controller, the datapath and the top level of the FNV-1a 64-bit hash unit
// depends on nothing
package fnv1a64_pkg;

  localparam int unsigned HASH_W   = 64;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BYTES_W  = HASH_W / BYTE_W;
  localparam int unsigned BCNT_W   = $clog2(BYTES_W);

  localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [BYTE_W-1:0] FNV_DELIMITER    = 8'hff;
  localparam logic [BCNT_W-1:0] LAST_BYTE_IDX    = BCNT_W'(BYTES_W - 1);

  // request operation codes
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELIM = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_WORD  = 2'd3;

  // datapath hash register operations
  localparam logic [1:0] HOP_HOLD  = 2'd0;
  localparam logic [1:0] HOP_BASIS = 2'd1;
  localparam logic [1:0] HOP_FOLD  = 2'd2;

  // byte source for a fold
  localparam logic [1:0] BSEL_DATA  = 2'd0;
  localparam logic [1:0] BSEL_DELIM = 2'd1;
  localparam logic [1:0] BSEL_WORD  = 2'd2;

  typedef struct packed {
    logic [1:0] hash_op;
    logic [1:0] byte_sel;
    logic       load_word;
  } dp_cmd_t;

  typedef struct packed {
    logic last_byte;
  } dp_status_t;

  // xor in one byte, then multiply by the prime 2^40 + 2^8 + 0xb3 as a shift-add
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = acc ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

FILE: sv/fnv1a_64_stream_hash_unit.sv
// fnv1a_64_stream_hash_unit: top level of the running FNV-1a 64-bit hash engine
// depends on fnv1a64_pkg, fnv1a64_ctrl and fnv1a64_datapath
//
// usage
//   request channel: in_valid/in_ready with func and data_value. func selects
//   start (reload offset basis), byte (fold data_value[7:0]), delimiter (fold 0xff)
//   or word (fold all eight bytes of data_value, least significant first).
//   result channel: out_valid/out_ready with hash_value, one result per request,
//   the running hash after that request.
// latency and throughput
//   start, byte and delimiter requests: result valid the cycle after acceptance,
//   one request per cycle while the receiver takes every result.
//   word requests: one byte folded per cycle through the shared fold unit, so the
//   result appears after the eighth fold and no new request is taken before it.
// reset
//   rst (synchronous) loads the offset basis and empties the result slot.
// receiver stall
//   the hash register doubles as the result slot; while a result waits, in_ready
//   stays low unless out_ready is high in that same cycle.
module fnv1a_64_stream_hash_unit import fnv1a64_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [HASH_W-1:0] data_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] hash_value
);

  // command and status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  fnv1a64_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // hash register, word shifter and byte counter
  fnv1a64_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .data_value (data_value),
    .status     (status),
    .hash       (hash_value)
  );

endmodule

FILE: sv/fnv1a64_datapath.sv
// fnv1a64_datapath: running hash register, word shift register and byte counter
// depends on fnv1a64_pkg
module fnv1a64_datapath import fnv1a64_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [HASH_W-1:0] data_value,
  output dp_status_t        status,
  output logic [HASH_W-1:0] hash
);

  logic [HASH_W-1:0] hash_next;
  logic [HASH_W-1:0] word;
  logic [BCNT_W-1:0] byte_cnt;
  logic [BYTE_W-1:0] fold_byte;

  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_DATA:  fold_byte = data_value[BYTE_W-1:0];
      BSEL_DELIM: fold_byte = FNV_DELIMITER;
      BSEL_WORD:  fold_byte = word[BYTE_W-1:0];
      default:    fold_byte = word[BYTE_W-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.hash_op)
      HOP_BASIS: hash_next = FNV_OFFSET_BASIS;
      HOP_FOLD:  hash_next = fnv_fold(hash, fold_byte);
      default:   hash_next = hash;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= FNV_OFFSET_BASIS;
    end else begin
      hash <= hash_next;
    end
  end

  // word bytes go out least significant first
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      word     <= data_value;
      byte_cnt <= '0;
    end else if (cmd.byte_sel == BSEL_WORD && cmd.hash_op == HOP_FOLD) begin
      word     <= word >> BYTE_W;
      byte_cnt <= byte_cnt + BCNT_W'(1);
    end
  end

  assign status.last_byte = (byte_cnt == LAST_BYTE_IDX);

endmodule

FILE: sv/fnv1a64_ctrl.sv
// fnv1a64_ctrl: request/result handshake and word sequencing state machine
// depends on fnv1a64_pkg
module fnv1a64_ctrl import fnv1a64_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  output logic              out_valid,
  input  logic              out_ready,
  input  dp_status_t        status,
  output dp_cmd_t           cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORD = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.hash_op    = HOP_HOLD;
    cmd.byte_sel   = BSEL_DATA;
    cmd.load_word  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_START: begin
              cmd.hash_op    = HOP_BASIS;
              out_valid_next = 1'b1;
            end
            FUNC_BYTE: begin
              cmd.hash_op    = HOP_FOLD;
              cmd.byte_sel   = BSEL_DATA;
              out_valid_next = 1'b1;
            end
            FUNC_DELIM: begin
              cmd.hash_op    = HOP_FOLD;
              cmd.byte_sel   = BSEL_DELIM;
              out_valid_next = 1'b1;
            end
            default: begin
              cmd.load_word  = 1'b1;
              out_valid_next = 1'b0;
              state_next     = ST_WORD;
            end
          endcase
        end
      end
      default: begin
        cmd.hash_op  = HOP_FOLD;
        cmd.byte_sel = BSEL_WORD;
        if (status.last_byte) begin
          state_next     = ST_IDLE;
          out_valid_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_req_in_word: assert property (@(posedge clk) disable iff (rst)
    state == ST_WORD |-> !in_ready && !out_valid)
    else $error("request taken or result shown while folding a word");

  a_word_enters_seq: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_WORD |=> state == ST_WORD && !out_valid)
    else $error("word request did not start the fold sequence");

  a_word_ends_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_WORD && status.last_byte |=> state == ST_IDLE && out_valid)
    else $error("word fold sequence did not end in a result");

  a_single_req_result: assert property (@(posedge clk) disable iff (rst)
    accept && func != FUNC_WORD |=> out_valid)
    else $error("single-step request gave no result");
`endif

endmodule
